>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the inode cache RTL.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ICRT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ICRT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/icrt_pkg.sv
// ---------------------------------------------------------------------------
// icrt_pkg
// Types and constants of the reference-counted inode cache table.
// ---------------------------------------------------------------------------
package icrt_pkg;

  // Default configuration of the table
  localparam int SLOT_COUNT_DEF       = 64;
  localparam int INODES_PER_BLOCK_DEF = 8;

  // Configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam logic REG_TABLE_START = 1'b0;  // word index of inode_table_start

  // Reference count limit
  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  // Operation codes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_LOADED    = 3'd1,
    ST_FULL      = 3'd2,
    ST_HELD      = 3'd3,
    ST_CLEAN     = 3'd4,
    ST_WRITEBACK = 3'd5,
    ST_UNREF     = 3'd6,
    ST_SAT       = 3'd7
  } status_t;

  // Input transaction
  typedef struct packed {
    logic        opcode;
    logic [15:0] device;
    logic [31:0] inode_number;
    logic [5:0]  slot_index;
    logic        dirty_mark;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    status_t     status;
    logic [5:0]  slot_out;
    logic [31:0] disk_block;
    logic [2:0]  block_offset;
    logic [15:0] device_out;
    logic [31:0] inode_out;
  } out_item_t;

  // One slot of the table as stored in memory
  typedef struct packed {
    logic [15:0] device;
    logic [31:0] inode;
    logic [15:0] refs;
    logic        dirty;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ACQ_EVAL,
    S_REL_EVAL,
    S_DIV,
    S_RESP
  } state_t;

endpackage

>>> hw/rtl/icrt_stream_if.sv
// ---------------------------------------------------------------------------
// icrt_stream_if
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface icrt_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> hw/rtl/icrt_ram.sv
// ---------------------------------------------------------------------------
// icrt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module icrt_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/icrt_div.sv
// ---------------------------------------------------------------------------
// icrt_div
// Divider by a fixed divisor: reciprocal multiply, then one adjust step.
// ---------------------------------------------------------------------------
module icrt_div #(
  parameter  int DIVISOR = icrt_pkg::INODES_PER_BLOCK_DEF,
  localparam int RW      = $clog2(DIVISOR + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [31:0]   dividend,
  output logic          done,
  output logic [31:0]   quotient,
  output logic [RW-1:0] remainder
);

  // Reciprocal of the divisor scaled by 2^SHIFT, rounded down
  localparam int          SHIFT   = 32 + $clog2(DIVISOR);
  localparam logic [63:0] SCALE   = 64'd1 << SHIFT;
  localparam logic [32:0] RECIP   = 33'(SCALE / 64'(DIVISOR));
  localparam logic [31:0] DIV_VAL = 32'(DIVISOR);

  logic          est_v_r;
  logic          done_r;
  logic [31:0]   num_r;
  logic [31:0]   est_r, est_nxt;
  logic [31:0]   q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [64:0]   product;
  logic [31:0]   rem_full;

  // Estimate the quotient: exact or one below
  assign product = 65'(dividend) * 65'(RECIP);
  assign est_nxt = 32'(product >> SHIFT);

  // Remainder of the estimate stays below twice the divisor
  assign rem_full = num_r - 32'(est_r * DIV_VAL);

  // Adjust the estimate up by one where the remainder overflows
  always_comb begin
    if (rem_full >= DIV_VAL) begin
      q_nxt   = est_r + 32'd1;
      rem_nxt = RW'(rem_full - DIV_VAL);
    end else begin
      q_nxt   = est_r;
      rem_nxt = RW'(rem_full);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_v_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      est_v_r <= start;
      done_r  <= est_v_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      est_r <= est_nxt;
    end
    if (est_v_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

>>> hw/rtl/inode_cache_refcount_table_top.sv
// ---------------------------------------------------------------------------
// inode_cache_refcount_table_top
// Reference-counted in-core inode slot table held in one slot memory.
//
//   channel  direction  payload
//   in_ch    sink       opcode, device, inode_number, slot_index, dirty_mark
//   out_ch   source     status, slot_out, disk_block, block_offset,
//                       device_out, inode_out
//   cfg_*    APB slave  inode_table_start at byte address 0
//
// After reset a clearing pass zeroes the slot memory,
// during which no transaction is accepted; config writes are taken.
// Acquire: memory scan, evaluate, respond; a load adds a divide step.
// Release: modify/write, then respond; a write back adds a divide step.
// One transaction is in work at a time; the next one is accepted while the
// previous result waits in the output register, which stalls the respond step.
// ---------------------------------------------------------------------------
module inode_cache_refcount_table_top #(
  parameter int SLOT_COUNT       = icrt_pkg::SLOT_COUNT_DEF,
  parameter int INODES_PER_BLOCK = icrt_pkg::INODES_PER_BLOCK_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  icrt_stream_if.sink                     in_ch,
  icrt_stream_if.source                   out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [icrt_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [icrt_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [icrt_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  `include "assert_macros.svh"

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int RW = $clog2(INODES_PER_BLOCK + 1);

  icrt_pkg::state_t    state_r, state_nxt;
  icrt_pkg::in_item_t  item_r, item_nxt;
  icrt_pkg::out_item_t res_r, res_nxt;
  icrt_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [AW:0]   cnt_r, cnt_nxt;
  logic          chk_v_r, chk_v_nxt;
  logic [AW-1:0] chk_r, chk_nxt;
  logic          hit_v_r, hit_v_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [15:0]   hit_refs_r, hit_refs_nxt;
  logic          hit_dirty_r, hit_dirty_nxt;
  logic          free_v_r, free_v_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [AW-1:0] rel_idx;

  logic [31:0] table_start_r;

  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  icrt_pkg::slot_t           ram_wslot, rd;
  logic [icrt_pkg::SLOT_W-1:0] ram_rdata;

  logic          div_start, div_done;
  logic [31:0]   div_dividend, div_quot;
  logic [RW-1:0] div_rem;
  logic          in_acc;
  logic          cfg_wr;

  assign rd      = ram_rdata;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign rel_idx = AW'(item_r.slot_index);

  // Slot memory
  icrt_ram #(
    .WIDTH (icrt_pkg::SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wslot),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Block and offset of an inode
  icrt_div #(
    .DIVISOR (INODES_PER_BLOCK)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Configuration port
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == icrt_pkg::REG_TABLE_START) ? table_start_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_start_r <= '0;
    end else if (cfg_wr && cfg_paddr[2] == icrt_pkg::REG_TABLE_START) begin
      table_start_r <= cfg_pwdata;
    end
  end

  // Channel outputs
  assign in_ch.ready  = (state_r == icrt_pkg::S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Sequencer: next state, memory access and result assembly
  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    chk_v_nxt     = 1'b0;
    chk_nxt       = chk_r;
    hit_v_nxt     = hit_v_r;
    hit_idx_nxt   = hit_idx_r;
    hit_refs_nxt  = hit_refs_r;
    hit_dirty_nxt = hit_dirty_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wslot     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    div_start     = 1'b0;
    div_dividend  = '0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      // Zero one slot per cycle after reset
      icrt_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == (AW + 1)'(SLOT_COUNT - 1)) begin
          state_nxt = icrt_pkg::S_IDLE;
        end
      end

      // Take a transaction and dispatch it
      icrt_pkg::S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_ch.data;
          res_nxt  = '0;
          if (in_ch.data.opcode == icrt_pkg::OP_ACQUIRE) begin
            if (in_ch.data.inode_number == '0) begin
              res_nxt.status = icrt_pkg::ST_FULL;
              state_nxt      = icrt_pkg::S_RESP;
            end else begin
              cnt_nxt    = '0;
              hit_v_nxt  = 1'b0;
              free_v_nxt = 1'b0;
              state_nxt  = icrt_pkg::S_SCAN;
            end
          end else if (int'(in_ch.data.slot_index) >= SLOT_COUNT) begin
            res_nxt.status = icrt_pkg::ST_UNREF;
            state_nxt      = icrt_pkg::S_RESP;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(in_ch.data.slot_index);
            state_nxt = icrt_pkg::S_REL_EVAL;
          end
        end
      end

      // Read every slot, note first match and first free slot
      icrt_pkg::S_SCAN: begin
        if (cnt_r != (AW + 1)'(SLOT_COUNT)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[AW-1:0];
          cnt_nxt   = cnt_r + 1'b1;
          chk_v_nxt = 1'b1;
          chk_nxt   = cnt_r[AW-1:0];
        end else begin
          state_nxt = icrt_pkg::S_ACQ_EVAL;
        end
        if (chk_v_r) begin
          if (!hit_v_r && rd.device == item_r.device
              && rd.inode == item_r.inode_number) begin
            hit_v_nxt     = 1'b1;
            hit_idx_nxt   = chk_r;
            hit_refs_nxt  = rd.refs;
            hit_dirty_nxt = rd.dirty;
          end
          if (!free_v_r && rd.refs == '0) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = chk_r;
          end
        end
      end

      // Bump a hit, claim a free slot or report full
      icrt_pkg::S_ACQ_EVAL: begin
        state_nxt = icrt_pkg::S_RESP;
        if (hit_v_r) begin
          res_nxt.slot_out  = 6'(hit_idx_r);
          res_nxt.inode_out = item_r.inode_number;
          if (hit_refs_r == icrt_pkg::REFS_MAX) begin
            res_nxt.status = icrt_pkg::ST_SAT;
          end else begin
            res_nxt.status  = icrt_pkg::ST_HIT;
            ram_we          = 1'b1;
            ram_waddr       = hit_idx_r;
            ram_wslot       = '{device: item_r.device, inode: item_r.inode_number,
                                refs: hit_refs_r + 16'd1, dirty: hit_dirty_r};
          end
        end else if (free_v_r) begin
          res_nxt.status     = icrt_pkg::ST_LOADED;
          res_nxt.slot_out   = 6'(free_idx_r);
          res_nxt.device_out = item_r.device;
          res_nxt.inode_out  = item_r.inode_number;
          ram_we             = 1'b1;
          ram_waddr          = free_idx_r;
          ram_wslot          = '{device: item_r.device, inode: item_r.inode_number,
                                 refs: 16'd1, dirty: 1'b0};
          div_start          = 1'b1;
          div_dividend       = item_r.inode_number - 32'd1;
          state_nxt          = icrt_pkg::S_DIV;
        end else begin
          res_nxt.status = icrt_pkg::ST_FULL;
        end
      end

      // Drop one reference, fold in the dirty mark
      icrt_pkg::S_REL_EVAL: begin
        state_nxt = icrt_pkg::S_RESP;
        if (rd.refs == '0) begin
          res_nxt.status = icrt_pkg::ST_UNREF;
        end else begin
          res_nxt.slot_out  = item_r.slot_index;
          res_nxt.inode_out = rd.inode;
          ram_we            = 1'b1;
          ram_waddr         = rel_idx;
          ram_wslot         = '{device: rd.device, inode: rd.inode,
                                refs: rd.refs - 16'd1,
                                dirty: rd.dirty | item_r.dirty_mark};
          if (rd.refs != 16'd1) begin
            res_nxt.status = icrt_pkg::ST_HELD;
          end else if (rd.dirty || item_r.dirty_mark) begin
            res_nxt.status     = icrt_pkg::ST_WRITEBACK;
            res_nxt.device_out = rd.device;
            ram_wslot.dirty    = 1'b0;
            div_start          = 1'b1;
            div_dividend       = rd.inode - 32'd1;
            state_nxt          = icrt_pkg::S_DIV;
          end else begin
            res_nxt.status = icrt_pkg::ST_CLEAN;
          end
        end
      end

      // Wait for block and offset
      icrt_pkg::S_DIV: begin
        if (div_done) begin
          res_nxt.disk_block   = div_quot + table_start_r;
          res_nxt.block_offset = 3'(div_rem);
          state_nxt            = icrt_pkg::S_RESP;
        end
      end

      // Hand the result to the output register once it is free
      icrt_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = icrt_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = icrt_pkg::S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icrt_pkg::S_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      chk_v_r     <= 1'b0;
      hit_v_r     <= 1'b0;
      free_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      chk_v_r     <= chk_v_nxt;
      hit_v_r     <= hit_v_nxt;
      free_v_r    <= free_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
    chk_r       <= chk_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_refs_r  <= hit_refs_nxt;
    hit_dirty_r <= hit_dirty_nxt;
    free_idx_r  <= free_idx_nxt;
  end

  // Checks
  `ICRT_ASSERT_NXT(a_busy_after_accept, in_acc, state_r != icrt_pkg::S_IDLE,
                   "sequencer idle right after an accepted transaction")
  `ICRT_ASSERT_IMP(a_no_rw_same_slot, ram_we && ram_re, ram_waddr != ram_raddr,
                   "slot read and written in the same cycle")
  `ICRT_ASSERT_IMP(a_div_done_in_wait, div_done, state_r == icrt_pkg::S_DIV,
                   "divider finished outside its wait state")
  `ICRT_ASSERT_IMP(a_result_from_resp, $rose(out_valid_r),
                   $past(state_r == icrt_pkg::S_RESP),
                   "result raised without a response step")

endmodule

>>> tb/tb_inode_cache_refcount_table_top.sv
// ----------------------------------------------------------------------------
// Inode cache reference-count table testbench
// Drives acquire and release transactions through the valid/ready input
// channel and checks every result against a cycle-free shadow of the slot
// table. A short directed run covers the corner cases. Random phases follow,
// each setting a table start block and an idle pattern.
// ----------------------------------------------------------------------------
module tb_inode_cache_refcount_table_top;
  import icrt_pkg::*;

  localparam int SLOTS          = SLOT_COUNT_DEF;
  localparam int IPB            = INODES_PER_BLOCK_DEF;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 204;
  localparam int SETTLE_CYCLES  = 120;
  localparam int QUIET_LIMIT    = 4000;
  localparam logic [CFG_ADDR_W-1:0] TABLE_START_ADDR = {REG_TABLE_START, 2'b00};

  // Shadow of the slot table; queues the reply each request must produce
  class slot_table_shadow;
    logic [15:0] slot_dev   [SLOTS];
    logic [31:0] slot_ino   [SLOTS];
    logic [15:0] slot_refs  [SLOTS];
    logic        slot_dirty [SLOTS];
    logic [31:0] table_start;
    out_item_t   replies_due [$];
    int          mismatch_count;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        slot_dev[i]   = '0;
        slot_ino[i]   = '0;
        slot_refs[i]  = '0;
        slot_dirty[i] = 1'b0;
      end
      table_start    = '0;
      mismatch_count = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    // Build a reply that carries the on-disk location of slot s
    function out_item_t located(status_t st, int s);
      out_item_t   r;
      logic [31:0] z;
      z              = slot_ino[s] - 32'd1;
      r.status       = st;
      r.slot_out     = 6'(s);
      r.disk_block   = z / 32'(IPB) + table_start;
      r.block_offset = 3'(z % 32'(IPB));
      r.device_out   = slot_dev[s];
      r.inode_out    = slot_ino[s];
      return r;
    endfunction

    function void apply_request(in_item_t it);
      out_item_t r;
      int        i;
      int        hit;
      int        free;
      r    = '0;
      hit  = -1;
      free = -1;
      if (it.opcode == OP_ACQUIRE) begin
        // Inode zero is refused outright: leave hit and free unset
        if (it.inode_number != '0) begin
          for (i = SLOTS - 1; i >= 0; i--) begin
            if (slot_dev[i] == it.device && slot_ino[i] == it.inode_number) hit = i;
            if (slot_refs[i] == '0) free = i;
          end
        end
        if (hit >= 0) begin
          r.slot_out  = 6'(hit);
          r.inode_out = it.inode_number;
          if (slot_refs[hit] == REFS_MAX) begin
            r.status = ST_SAT;
          end else begin
            slot_refs[hit]++;
            r.status = ST_HIT;
          end
        end else if (free >= 0) begin
          // Claim the first free slot, starting clean
          slot_refs[free]  = 16'd1;
          slot_dev[free]   = it.device;
          slot_ino[free]   = it.inode_number;
          slot_dirty[free] = 1'b0;
          r = located(ST_LOADED, free);
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        i = it.slot_index;
        if (i >= SLOTS || slot_refs[i] == '0) begin
          r.status = ST_UNREF;
        end else begin
          slot_dirty[i] = slot_dirty[i] | it.dirty_mark;
          slot_refs[i]--;
          r.slot_out  = 6'(i);
          r.inode_out = slot_ino[i];
          if (slot_refs[i] != '0) begin
            r.status = ST_HELD;
          end else if (slot_dirty[i]) begin
            slot_dirty[i] = 1'b0;
            r = located(ST_WRITEBACK, i);
          end else begin
            r.status = ST_CLEAN;
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatch_count++;
    endfunction

    function void compare_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("unexpected result transaction: status %0d slot %0d", got.status, got.slot_out);
        mismatch_count++;
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status)       report("status", want.status, got.status);
      if (got.slot_out !== want.slot_out)   report("slot_out", want.slot_out, got.slot_out);
      if (got.disk_block !== want.disk_block)
        report("disk_block", want.disk_block, got.disk_block);
      if (got.block_offset !== want.block_offset)
        report("block_offset", want.block_offset, got.block_offset);
      if (got.device_out !== want.device_out)
        report("device_out", want.device_out, got.device_out);
      if (got.inode_out !== want.inode_out) report("inode_out", want.inode_out, got.inode_out);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    gap_pct;
  int                    stall_pct;
  int                    quiet_cycles;
  slot_table_shadow      sb;

  icrt_stream_if #(.payload_t(in_item_t))  in_ch ();
  icrt_stream_if #(.payload_t(out_item_t)) out_ch ();

  inode_cache_refcount_table_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Track accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.apply_request(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.compare_reply(out_ch.data);
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no transaction for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall at the rate of the current phase
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t acquire_item(logic [15:0] dev, logic [31:0] ino);
    in_item_t it;
    it.opcode       = OP_ACQUIRE;
    it.device       = dev;
    it.inode_number = ino;
    it.slot_index   = 6'($urandom);
    it.dirty_mark   = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t release_item(logic [5:0] s, logic mark);
    in_item_t it;
    it.opcode       = OP_RELEASE;
    it.device       = 16'($urandom);
    it.inode_number = $urandom;
    it.slot_index   = s;
    it.dirty_mark   = mark;
    return it;
  endfunction

  // Mostly a small pool of inodes and held slots, so hits, fills and
  // write-backs keep happening; the rest is unconstrained
  function automatic in_item_t random_item(int acq_pct);
    int          k;
    int          s;
    int          start;
    int          pick;
    logic [15:0] dev;
    logic [31:0] ino;
    in_item_t    it;
    pick = $urandom_range(99);
    if ($urandom_range(99) < acq_pct) begin
      if (pick < 85) begin
        k   = $urandom_range(95);
        dev = (k % 4 == 0) ? 16'h0000 : (k % 4 == 1) ? 16'h0001 :
              (k % 4 == 2) ? 16'h8000 : 16'hFFFF;
        ino = (k / 4 >= 20) ? 32'hFFFF_FFFF - 32'(k / 4 - 20) : 32'(k / 4 + 1);
        it  = acquire_item(dev, ino);
      end else if (pick < 95) begin
        it = acquire_item(16'($urandom), $urandom);
      end else begin
        it = acquire_item(16'($urandom), '0);
      end
    end else begin
      start = $urandom_range(SLOTS - 1);
      s     = start;
      if (pick < 85) begin
        for (k = 0; k < SLOTS; k++) begin
          s = (start + k) % SLOTS;
          if (sb.slot_refs[s] != '0) break;
        end
      end
      it = release_item(6'(s), 1'($urandom));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.data  = it;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off the sender until every result is back
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic write_table_start(input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = TABLE_START_ADDR;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.table_start = value;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Corner cases, with a table start that makes block numbers wrap
  task automatic run_directed();
    send_item(acquire_item(16'h0000, 32'd1));           // load into slot 0
    send_item(acquire_item(16'hFFFF, 32'hFFFF_FFFF));   // load, block wraps
    send_item(acquire_item(16'h0000, 32'd1));           // hit
    send_item(acquire_item(16'hFFFF, 32'd0));           // inode zero refused
    send_item(acquire_item(16'h0000, 32'd0));
    send_item(release_item(6'd0, 1'b1));                // still held, marked
    send_item(release_item(6'd0, 1'b0));                // write back
    send_item(release_item(6'd0, 1'b1));                // free slot, mark ignored
    send_item(acquire_item(16'h0000, 32'd1));           // hit on unreferenced slot
    send_item(release_item(6'd0, 1'b0));                // clean release
    send_item(release_item(6'd63, 1'b1));               // never claimed
    send_item(acquire_item(16'h0001, 32'd1));           // reclaims slot 0
    send_item(acquire_item(16'h0000, 32'd1));           // evicted pair, new slot
    send_item(release_item(6'd1, 1'b1));                // write back, wrapped block
    send_item(acquire_item(16'h8000, 32'd8));           // last inode of a block
    send_item(acquire_item(16'h8000, 32'd9));           // first inode of the next
    send_item(release_item(6'd0, 1'b0));                // claimed slot starts clean
  endtask

  initial begin : stimulus
    int          p;
    int          n;
    int          acq_pct;
    logic [31:0] start_blk;
    sb             = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.data     = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    write_table_start(32'hFFFF_FFF0);
    run_directed();

    for (p = 0; p < PHASES; p++) begin
      wait_for_results();
      gap_pct   = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 11 : 0;
      stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 11 : 0;
      acq_pct   = (p % 2 == 0) ? 60 : 42;
      case (p)
        0, 5:    start_blk = 32'h0000_0000;
        1, 4:    start_blk = 32'hFFFF_FFFF;
        3:       start_blk = 32'h0000_0001;
        7:       start_blk = 32'h8000_0000;
        default: start_blk = $urandom;
      endcase
      write_table_start(start_blk);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_for_results();
        send_item(random_item(acq_pct));
      end
    end

    // Drain, then let any stray result show up
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
